// ===== rtl/core/rbfs_pkg.sv =====
// shared constants for the rotated bitmap frame size block
`timescale 1ns / 1ps

package rbfs_pkg;

    // radicand bits consumed by one root cell
    localparam int DIGIT_BITS = 2;

    // result field widths
    localparam int SIDE_W   = 13;
    localparam int CENTRE_W = 12;
    localparam int OUT_W    = 32;

endpackage

// ===== rtl/core/rotated_bitmap_frame_size_top.sv =====
// top level: reach, squares, root cell chain and result register
// an accepted word passes the reach, square, root cell and output registers before m_axis_tvalid
// one word in flight at a time: a new word waits until the previous result lands in the output register
// the chain has COORD_BITS+1 cells, one radicand digit pair each
// a new word is taken while the previous result waits in the output register
// reset: synchronous active low, clears all valid flags and the busy flag
`timescale 1ns / 1ps

module rotated_bitmap_frame_size_top #(
    parameter int COORD_BITS = 11
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // bitmap_width, bitmap_height, pivot_x, pivot_y from bit 0 up, zero padded
    input  logic [((4*COORD_BITS-2+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // frame_side, frame_centre from bit 0 up, zero padded
    output logic [rbfs_pkg::OUT_W-1:0]                m_axis_tdata
);

    localparam int C      = COORD_BITS;
    localparam int ROOT_W = C + 1;
    localparam int RAD_W  = rbfs_pkg::DIGIT_BITS * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int NCELL  = ROOT_W;
    localparam int SW     = rbfs_pkg::SIDE_W;
    localparam int CW     = rbfs_pkg::CENTRE_W;
    localparam int SEXT_W = (C + 2 > SW) ? C + 2 : SW;
    localparam int CEXT_W = (ROOT_W > CW) ? ROOT_W : CW;

    logic [C-2:0]        in_width;
    logic [C-2:0]        in_height;
    logic [C-1:0]        in_px;
    logic [C-1:0]        in_py;
    logic [C-1:0]        reach_x;
    logic [C-1:0]        reach_y;
    logic                accept;
    logic                en;
    logic                r_busy;
    logic                r_reach_v;
    logic [C-1:0]        r_rx;
    logic [C-1:0]        r_ry;
    logic                r_sq_v;
    logic [2*C-1:0]      r_sqx;
    logic [2*C-1:0]      r_sqy;
    logic [2*C:0]        sq_sum;
    logic                r_out_v;
    logic [SW-1:0]       r_side;
    logic [CW-1:0]       r_centre;
    logic [SEXT_W-1:0]   side_ext;
    logic [CEXT_W-1:0]   centre_ext;
    logic                w_valid [0:NCELL];
    logic [RAD_W-1:0]    w_rad   [0:NCELL];
    logic [REM_W-1:0]    w_rem   [0:NCELL];
    logic [ROOT_W-1:0]   w_root  [0:NCELL];
    logic [NCELL+1:0]    stage_v;

    // reach on one axis: max of pivot and |dimension - pivot|
    function automatic logic [C-1:0] f_reach(input logic [C-2:0] dim, input logic [C-1:0] piv);
        logic signed [C:0] diff;
        logic [C:0]        mag;
        logic [C-1:0]      ppos;
        diff = $signed({2'b00, dim}) - $signed({piv[C-1], piv});
        mag  = diff[C] ? (~diff + 1'b1) : diff;
        ppos = piv[C-1] ? '0 : piv;
        return (ppos > mag[C-1:0]) ? ppos : mag[C-1:0];
    endfunction

    // field unpack
    assign in_width  = s_axis_tdata[C-2:0];
    assign in_height = s_axis_tdata[2*C-3:C-1];
    assign in_px     = s_axis_tdata[3*C-3:2*C-2];
    assign in_py     = s_axis_tdata[4*C-3:3*C-2];
    assign reach_x   = f_reach(in_width, in_px);
    assign reach_y   = f_reach(in_height, in_py);

    // handshake and chain advance
    assign s_axis_tready = !r_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign en            = !(w_valid[NCELL] && r_out_v && !m_axis_tready);

    // busy from accept until the result lands in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (en && w_valid[NCELL]) begin
            r_busy <= 1'b0;
        end
    end

    // reach and square stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach_v <= 1'b0;
            r_sq_v    <= 1'b0;
        end else if (en) begin
            r_reach_v <= accept;
            r_sq_v    <= r_reach_v;
        end
    end

    // reach and square payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx  <= reach_x;
            r_ry  <= reach_y;
            r_sqx <= {{C{1'b0}}, r_rx} * {{C{1'b0}}, r_rx};
            r_sqy <= {{C{1'b0}}, r_ry} * {{C{1'b0}}, r_ry};
        end
    end

    // chain head: radicand, empty remainder and root
    assign sq_sum     = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_valid[0] = r_sq_v;
    assign w_rad[0]   = RAD_W'(sq_sum);
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;

    // root cell chain
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        rbfs_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_rad   (w_rad[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .o_valid (w_valid[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1])
        );
    end

    // side is twice the root plus one, centre is the root
    assign side_ext   = SEXT_W'({w_root[NCELL], 1'b1});
    assign centre_ext = CEXT_W'(w_root[NCELL]);

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en && w_valid[NCELL]) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (en && w_valid[NCELL]) begin
            r_side   <= side_ext[SW-1:0];
            r_centre <= centre_ext[CW-1:0];
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(rbfs_pkg::OUT_W-SW-CW){1'b0}}, r_centre, r_side};

    // stage occupancy, one item in flight at most
    always_comb begin
        stage_v[0] = r_reach_v;
        stage_v[1] = r_sq_v;
        for (int k = 0; k < NCELL; k++) begin
            stage_v[k+2] = w_valid[k+1];
        end
    end

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(stage_v))
        else $error("more than one item in the frame size pipeline");

    a_busy_covers_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_v != '0) |-> r_busy)
        else $error("item in flight while busy is clear");

    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (stage_v == '0))
        else $error("word accepted with pipeline occupied");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && w_valid[NCELL]) |=> (m_axis_tvalid && !r_busy))
        else $error("chain result not loaded into output register");

endmodule

// ===== rtl/core/rbfs_cell.sv =====
// one digit cell of the square root chain
`timescale 1ns / 1ps

module rbfs_cell #(
    parameter int ROOT_W = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [rbfs_pkg::DIGIT_BITS*ROOT_W-1:0]      i_rad,
    input  logic [ROOT_W+1:0]                          i_rem,
    input  logic [ROOT_W-1:0]                          i_root,
    output logic                                       o_valid,
    output logic [rbfs_pkg::DIGIT_BITS*ROOT_W-1:0]      o_rad,
    output logic [ROOT_W+1:0]                          o_rem,
    output logic [ROOT_W-1:0]                          o_root
);

    localparam int DB    = rbfs_pkg::DIGIT_BITS;
    localparam int RAD_W = DB * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;
    logic              r_valid;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [RAD_W-1:0]  n_rad;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;

    // bring down the next digit pair and try root*4+1
    always_comb begin
        rem_sh = {i_rem[REM_W-DB-1:0], i_rad[RAD_W-1 -: DB]};
        trial  = {i_root, 2'b01};
        fits   = (rem_sh >= trial);
        n_rem  = fits ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[ROOT_W-2:0], fits};
        n_rad  = {i_rad[RAD_W-DB-1:0], {DB{1'b0}}};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload hand-off to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule
